[design/dspg_pkg.sv]
// ----------------------------------------------------------------------------
// dspg_pkg
// Shared types, codes and constants of the dual stepper pulse generator.
// ----------------------------------------------------------------------------
package dspg_pkg;

	// Step direction codes
	localparam logic [1:0] DIR_HALT = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_STEPS_PER_REV = 2'd0;
	localparam logic [1:0] CFG_WHEEL_RADIUS  = 2'd1;
	localparam logic [1:0] CFG_TICK_RATE     = 2'd2;

	// Field widths
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;
	localparam int CPR_W     = 16;
	localparam int RAD_W     = 16;
	localparam int RATE_W    = 20;
	localparam int VEL_W     = 32;
	localparam int POS_W     = 16;
	localparam int DIR_W     = 2;

	// Register reset values
	localparam logic [CPR_W-1:0]  CPR_RST  = 16'd200;
	localparam logic [RAD_W-1:0]  RAD_RST  = 16'd3277;
	localparam logic [RATE_W-1:0] RATE_RST = 20'd62500;

	// pi in Q16.16
	localparam int                PI_W   = 18;
	localparam logic [PI_W-1:0]   PI_Q16 = 18'd205887;

	// Divisor datapath: product mag*C, denominator pi*R, 20 quotient bits
	localparam int PROD_W = VEL_W + CPR_W;     // 48
	localparam int NUM_W  = 64;
	localparam int DEN_W  = PI_W + RAD_W;      // 34
	localparam int QUO_W  = RATE_W;            // 20
	localparam int NUM_SH = 17;                // x2 and x65536

	localparam int PERIOD_WIDTH_DEF = 16;

	// Divider request and status
	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] lo;
		logic [DEN_W-1:0] divisor;
	} dspg_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dspg_div_sts_t;

	// Per-motor control
	typedef struct packed {
		logic             tick;
		logic             load;
		logic [DIR_W-1:0] dir;
	} dspg_chan_ctl_t;

endpackage

[design/dspg_if.sv]
// ----------------------------------------------------------------------------
// dspg_if
// Valid/ready channels of the dual stepper pulse generator: input items,
// results and configuration writes.
// ----------------------------------------------------------------------------
interface dspg_in_if;
	logic                               valid;
	logic                               ready;
	logic                               mode;
	logic                               motor;
	logic signed [dspg_pkg::VEL_W-1:0]  velocity;

	modport source (output valid, mode, motor, velocity, input ready);
	modport sink   (input valid, mode, motor, velocity, output ready);
endinterface

interface dspg_out_if;
	logic                       valid;
	logic                       ready;
	logic                       left_step;
	logic                       right_step;
	logic [dspg_pkg::POS_W-1:0] left_position;
	logic [dspg_pkg::POS_W-1:0] right_position;
	logic [dspg_pkg::DIR_W-1:0] left_direction;
	logic [dspg_pkg::DIR_W-1:0] right_direction;

	modport source (output valid, left_step, right_step, left_position, right_position,
		left_direction, right_direction, input ready);
	modport sink   (input valid, left_step, right_step, left_position, right_position,
		left_direction, right_direction, output ready);
endinterface

interface dspg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dspg_pkg::CFG_IDX_W-1:0] index;
	logic [dspg_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[design/dspg_div.sv]
// ----------------------------------------------------------------------------
// dspg_div
// Shared restoring divider: one quotient bit per cycle, fixed step count.
// ----------------------------------------------------------------------------
module dspg_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dspg_pkg::dspg_div_req_t req,
	output dspg_pkg::dspg_div_sts_t sts,
	output logic [dspg_pkg::QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(dspg_pkg::QUO_W + 1);

	logic [dspg_pkg::DEN_W-1:0] rem_q;
	logic [dspg_pkg::QUO_W-1:0] dvd_q;
	logic [dspg_pkg::DEN_W-1:0] dsr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [dspg_pkg::DEN_W:0]   shifted;
	logic [dspg_pkg::DEN_W:0]   trial;
	logic                       qbit;

	assign shifted = {rem_q, dvd_q[dspg_pkg::QUO_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign qbit    = ~trial[dspg_pkg::DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(dspg_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			dvd_q <= req.lo;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			// keep the difference when it stays non-negative
			rem_q <= qbit ? trial[dspg_pkg::DEN_W-1:0] : shifted[dspg_pkg::DEN_W-1:0];
			dvd_q <= {dvd_q[dspg_pkg::QUO_W-2:0], qbit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dvd_q;

endmodule

[design/dspg_chan.sv]
// ----------------------------------------------------------------------------
// dspg_chan
// One motor: tick counter, half period, direction, step level, position.
// ----------------------------------------------------------------------------
module dspg_chan #(
	parameter int PERIOD_WIDTH = dspg_pkg::PERIOD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dspg_pkg::dspg_chan_ctl_t       ctl,
	input  logic [PERIOD_WIDTH-1:0]        hp,
	input  logic [dspg_pkg::CPR_W-1:0]     step_modulus,
	output logic                           step,
	output logic [dspg_pkg::POS_W-1:0]     position,
	output logic [dspg_pkg::DIR_W-1:0]     direction
);

	logic [PERIOD_WIDTH-1:0]    cnt_q;
	logic [PERIOD_WIDTH-1:0]    hp_q;
	logic [dspg_pkg::DIR_W-1:0] dir_q;
	logic                       step_q;
	logic [dspg_pkg::POS_W-1:0] pos_q;

	logic [PERIOD_WIDTH-1:0]    cnt_inc;
	logic                       wrap;
	logic [dspg_pkg::POS_W:0]   modulus;
	logic [dspg_pkg::POS_W:0]   pos_up;
	logic [dspg_pkg::POS_W:0]   pos_next;

	assign cnt_inc = cnt_q + 1'b1;
	assign wrap    = (cnt_inc >= hp_q);
	// a zero modulus stands for the full 16-bit range
	assign modulus = (step_modulus == '0) ? {1'b1, {dspg_pkg::POS_W{1'b0}}}
		: {1'b0, step_modulus};
	assign pos_up  = {1'b0, pos_q} + 1'b1;

	always_comb begin
		if (dir_q == dspg_pkg::DIR_REV) begin
			if (pos_q == '0) begin
				pos_next = modulus - 1'b1;
			end else begin
				pos_next = {1'b0, pos_q} - 1'b1;
			end
		end else if (pos_up >= modulus) begin
			pos_next = pos_up - modulus;
		end else begin
			pos_next = pos_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hp_q   <= '0;
			dir_q  <= dspg_pkg::DIR_HALT;
			step_q <= 1'b0;
			pos_q  <= '0;
		end else if (ctl.load) begin
			hp_q  <= hp;
			dir_q <= ctl.dir;
		end else if (ctl.tick) begin
			cnt_q <= wrap ? '0 : cnt_inc;
			if (wrap && dir_q != dspg_pkg::DIR_HALT) begin
				step_q <= ~step_q;
				// advance on the rising edge only
				if (!step_q) begin
					pos_q <= pos_next[dspg_pkg::POS_W-1:0];
				end
			end
		end
	end

	assign step      = step_q;
	assign position  = pos_q;
	assign direction = dir_q;

endmodule

[design/dual_stepper_pulse_generator_core.sv]
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_core
// Two-channel stepper step-pulse generator with velocity-to-period divider.
// ----------------------------------------------------------------------------
// Each input transfer is a timer tick or a signed Q16.16 velocity command for
// one motor, and each yields one result transfer carrying both motors' step
// levels, positions and directions after the item. A tick is applied in the
// cycle it is taken, so its result is offered on the next cycle. A velocity
// command passes through the states MUL (the two products |v|*counts and
// pi*radius), CMP (one wide compare that screens out frequencies at or above
// 2^20 Hz), then two passes through the shared one-bit-per-cycle restoring
// divider (frequency, then tick_rate over frequency), each ending with a done
// pulse. The screen ends a command after the compare and a zero frequency
// ends it after the first pass. The block takes a new item only when idle and
// the result register is empty or being drained, so no item is taken until
// the command before it has finished; configuration writes are always taken
// and must be made while idle.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_core #(
	parameter int PERIOD_WIDTH = dspg_pkg::PERIOD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dspg_in_if.sink      item,
	dspg_out_if.source   result,
	dspg_cfg_if.sink     cfg
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;

	localparam int XW = (PERIOD_WIDTH > dspg_pkg::QUO_W) ? PERIOD_WIDTH : dspg_pkg::QUO_W;

	// configuration registers
	logic [dspg_pkg::CPR_W-1:0]  cpr_q;
	logic [dspg_pkg::RAD_W-1:0]  rad_q;
	logic [dspg_pkg::RATE_W-1:0] rate_q;

	// sequencer and command datapath
	logic [2:0]                  state_q;
	logic                        out_valid_q;
	logic                        motor_q;
	logic [dspg_pkg::DIR_W-1:0]  dir_q;
	logic [dspg_pkg::VEL_W-1:0]  mag_q;
	logic [dspg_pkg::PROD_W-1:0] prod_q;
	logic [dspg_pkg::DEN_W-1:0]  den_q;

	logic                        in_xfer;
	logic                        out_xfer;
	logic [dspg_pkg::VEL_W-1:0]  raw;
	logic [dspg_pkg::NUM_W-1:0]  num;
	logic [dspg_pkg::NUM_W-1:0]  den_big;
	logic                        load;
	logic [PERIOD_WIDTH-1:0]     hp;
	logic [dspg_pkg::QUO_W-1:0]  t_m1;
	logic [XW-1:0]               t_m1_x;

	dspg_pkg::dspg_div_req_t     div_req;
	dspg_pkg::dspg_div_sts_t     div_sts;
	logic [dspg_pkg::QUO_W-1:0]  quotient;

	dspg_pkg::dspg_chan_ctl_t    ctl_l;
	dspg_pkg::dspg_chan_ctl_t    ctl_r;

	assign in_xfer  = item.valid && item.ready;
	assign out_xfer = result.valid && result.ready;
	assign raw      = item.velocity;

	// take a new item only when idle and the result slot frees up
	assign item.ready   = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q  <= dspg_pkg::CPR_RST;
			rad_q  <= dspg_pkg::RAD_RST;
			rate_q <= dspg_pkg::RATE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				dspg_pkg::CFG_STEPS_PER_REV: cpr_q  <= cfg.data[dspg_pkg::CPR_W-1:0];
				dspg_pkg::CFG_WHEEL_RADIUS:  rad_q  <= cfg.data[dspg_pkg::RAD_W-1:0];
				dspg_pkg::CFG_TICK_RATE:     rate_q <= cfg.data[dspg_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// numerator 2*|v|*C*65536 and its screen against pi*R*2^20
	assign num     = {prod_q[dspg_pkg::NUM_W-dspg_pkg::NUM_SH-1:0], {dspg_pkg::NUM_SH{1'b0}}};
	assign den_big = {{(dspg_pkg::NUM_W-dspg_pkg::DEN_W-dspg_pkg::QUO_W){1'b0}}, den_q,
		{dspg_pkg::QUO_W{1'b0}}};

	// half period from t = tick_rate / q: t - 1, floored at zero, clamped
	assign t_m1   = (quotient == '0) ? '0 : quotient - 1'b1;
	assign t_m1_x = XW'(t_m1);

	always_comb begin
		div_req.start   = 1'b0;
		div_req.rem     = num[dspg_pkg::DEN_W+dspg_pkg::QUO_W-1:dspg_pkg::QUO_W];
		div_req.lo      = num[dspg_pkg::QUO_W-1:0];
		div_req.divisor = den_q;
		load            = 1'b0;
		hp              = '0;
		case (state_q)
			ST_CMP: begin
				if (num >= den_big) begin
					// frequency at or above 2^20: period collapses to zero
					load = 1'b1;
				end else begin
					div_req.start = 1'b1;
				end
			end
			ST_DIV1: begin
				if (div_sts.done) begin
					if (quotient == '0) begin
						load = 1'b1;
						hp   = '1;
					end else begin
						div_req.start   = 1'b1;
						div_req.rem     = '0;
						div_req.lo      = rate_q;
						div_req.divisor = {{(dspg_pkg::DEN_W-dspg_pkg::QUO_W){1'b0}}, quotient};
					end
				end
			end
			ST_DIV2: begin
				if (div_sts.done) begin
					load = 1'b1;
					hp   = (t_m1_x > XW'({PERIOD_WIDTH{1'b1}})) ? '1 : t_m1_x[PERIOD_WIDTH-1:0];
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((in_xfer && !item.mode) || load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_xfer && item.mode) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_CMP;
				ST_CMP:  state_q <= load ? ST_IDLE : ST_DIV1;
				ST_DIV1: begin
					if (load) begin
						state_q <= ST_IDLE;
					end else if (div_sts.done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command payload: hold motor, direction and magnitude, then form products
	always_ff @(posedge clk) begin
		if (in_xfer && item.mode) begin
			motor_q <= item.motor;
			if (raw[dspg_pkg::VEL_W-1]) begin
				dir_q <= dspg_pkg::DIR_REV;
				mag_q <= '0 - raw;
			end else begin
				dir_q <= (raw != '0) ? dspg_pkg::DIR_FWD : dspg_pkg::DIR_HALT;
				mag_q <= raw;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= mag_q * cpr_q;
			den_q  <= dspg_pkg::PI_Q16 * rad_q;
		end
	end

	dspg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// per-motor controls: ticks go to both, loads to the addressed one
	assign ctl_l.tick = in_xfer && !item.mode;
	assign ctl_l.load = load && !motor_q;
	assign ctl_l.dir  = dir_q;
	assign ctl_r.tick = in_xfer && !item.mode;
	assign ctl_r.load = load && motor_q;
	assign ctl_r.dir  = dir_q;

	dspg_chan #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_chan_l (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_l),
		.hp           (hp),
		.step_modulus (cpr_q),
		.step         (result.left_step),
		.position     (result.left_position),
		.direction    (result.left_direction)
	);

	dspg_chan #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_chan_r (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_r),
		.hp           (hp),
		.step_modulus (cpr_q),
		.step         (result.right_step),
		.position     (result.right_position),
		.direction    (result.right_direction)
	);

	// a half period is only ever loaded from a busy sequencer
	a_load_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> state_q != ST_IDLE)
		else $error("half period loaded while idle");

	// the shared divider is never restarted mid-division
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_sts.busy)
		else $error("divider started while busy");

	// a tick transfer always produces a result on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !item.mode) |=> result.valid)
		else $error("tick without result");

	// a stopped left motor holds its step level
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result.left_direction == dspg_pkg::DIR_HALT) |=> $stable(result.left_step))
		else $error("stopped left motor toggled");

endmodule
